// ===== hdl/upb_pkg.sv =====
// Shared types, sizes and level weighting for the unique palette builder.
package upb_pkg;

    // Number of palette entries, one cell each
    localparam int TABLE_DEPTH = 256;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int KEY_W       = 12;

    // Colour weights of the resistor ladder, bit 0 up to bit 3
    localparam logic [7:0] W_BIT0 = 8'h0e;
    localparam logic [7:0] W_BIT1 = 8'h1f;
    localparam logic [7:0] W_BIT2 = 8'h43;
    localparam logic [7:0] W_BIT3 = 8'h8f;

    // Search token passed from cell to cell
    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;        // {red, green, blue}
        logic             found;
        logic             is_new;
        logic [IDX_W-1:0] hit_index;
    } token_t;

    // Weighted 8-bit level of one 4-bit colour nibble
    function automatic logic [7:0] nibble_level(input logic [3:0] n);
        logic [9:0] s;
        s = 10'd0;
        if (n[0]) s = s + {2'b00, W_BIT0};
        if (n[1]) s = s + {2'b00, W_BIT1};
        if (n[2]) s = s + {2'b00, W_BIT2};
        if (n[3]) s = s + {2'b00, W_BIT3};
        return s[7:0];
    endfunction

endpackage

// ===== hdl/upb_cell.sv =====
// One palette cell: holds a single colour entry and passes the search token on.
module upb_cell (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [upb_pkg::IDX_W-1:0]  cell_index,
    input  logic [upb_pkg::CNT_W-1:0]  used,
    input  upb_pkg::token_t            tok_in,
    output upb_pkg::token_t            tok_out
);

    logic [upb_pkg::KEY_W-1:0] entry_reg;
    upb_pkg::token_t           tok_reg;
    upb_pkg::token_t           tok_next;
    logic                      wr_en;
    logic [upb_pkg::CNT_W-1:0] idx_ext;

    assign idx_ext = upb_pkg::CNT_W'(cell_index);

    // Match against a live entry, or claim this cell when it is the first free one
    always_comb
    begin
        tok_next = tok_in;
        wr_en    = 1'b0;
        if (tok_in.valid && !tok_in.found)
        begin
            if (idx_ext < used)
            begin
                if (entry_reg == tok_in.key)
                begin
                    tok_next.found     = 1'b1;
                    tok_next.hit_index = cell_index;
                end
            end
            else if (idx_ext == used)
            begin
                wr_en              = 1'b1;
                tok_next.found     = 1'b1;
                tok_next.is_new    = 1'b1;
                tok_next.hit_index = cell_index;
            end
        end
    end

    // Advance the token one cell per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    // Store the appended colour
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_reg <= tok_in.key;
        end
    end

    assign tok_out = tok_reg;

endmodule

// ===== hdl/unique_palette_builder.sv =====
// Top level of the unique palette builder: input stage, cell chain and result skid.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+---------------------------------------------
//  s_*     | in  | s_tvalid/s_tready  | tdata: red, green, blue nibbles; tuser: restart
//  m_*     | out | m_tvalid/m_tready  | tdata: index, red/green/blue levels; tuser: flags
//
// A colour's token is launched from the input register, walks the whole chain, registered
// in each cell, and lands in the output register, which presents the result.
// A new colour is taken once the previous token has left the chain and the skid is free.
// Reset empties the table count; entries are not cleared. A stalled result waits in
// the output register, with one more beat held in the skid stage.
module unique_palette_builder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [3:0] red_nibble, [7:4] green_nibble, [11:8] blue_nibble
    input  logic [0:0]  s_tuser,   // [0] restart
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] color_index, [15:8] red_level,
                                   // [23:16] green_level, [31:24] blue_level
    output logic [1:0]  m_tuser    // [0] is_new, [1] table_full
);

    localparam int N = upb_pkg::TABLE_DEPTH;

    upb_pkg::token_t           tok [N+1];
    upb_pkg::token_t           inj_reg;
    upb_pkg::token_t           out_reg;
    upb_pkg::token_t           hold_reg;
    logic                      busy_reg;
    logic                      out_valid_reg;
    logic                      hold_valid_reg;
    logic [upb_pkg::CNT_W-1:0] used_reg;
    logic                      in_fire;
    logic                      arrive;
    logic [3:0]                red_n;
    logic [3:0]                green_n;
    logic [3:0]                blue_n;

    assign s_tready = !busy_reg && !hold_valid_reg;
    assign in_fire  = s_tvalid && s_tready;
    assign arrive   = tok[N].valid;

    // Launch a token into the chain and track the fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inj_reg  <= '0;
            busy_reg <= 1'b0;
            used_reg <= '0;
        end
        else
        begin
            inj_reg.valid <= in_fire;
            if (in_fire)
            begin
                inj_reg.key       <= {s_tdata[3:0], s_tdata[7:4], s_tdata[11:8]};
                inj_reg.found     <= 1'b0;
                inj_reg.is_new    <= 1'b0;
                inj_reg.hit_index <= '0;
                busy_reg          <= 1'b1;
                if (s_tuser[0])
                begin
                    used_reg <= '0;
                end
            end
            else if (arrive)
            begin
                busy_reg <= 1'b0;
                if (tok[N].is_new)
                begin
                    used_reg <= used_reg + upb_pkg::CNT_W'(1);
                end
            end
        end
    end

    assign tok[0] = inj_reg;

    // Row of palette cells
    for (genvar i = 0; i < N; i++)
    begin : g_cell
        upb_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cell_index (upb_pkg::IDX_W'(i)),
            .used       (used_reg),
            .tok_in     (tok[i]),
            .tok_out    (tok[i+1])
        );
    end

    // Output register with one skid beat behind it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            hold_valid_reg <= 1'b0;
            out_reg        <= '0;
            hold_reg       <= '0;
        end
        else
        begin
            if (!out_valid_reg || m_tready)
            begin
                if (hold_valid_reg)
                begin
                    out_reg        <= hold_reg;
                    out_valid_reg  <= 1'b1;
                    hold_valid_reg <= 1'b0;
                end
                else if (arrive)
                begin
                    out_reg       <= tok[N];
                    out_valid_reg <= 1'b1;
                end
                else
                begin
                    out_valid_reg <= 1'b0;
                end
            end
            else if (arrive)
            begin
                hold_reg       <= tok[N];
                hold_valid_reg <= 1'b1;
            end
        end
    end

    // Form the result beat
    assign red_n    = out_reg.key[11:8];
    assign green_n  = out_reg.key[7:4];
    assign blue_n   = out_reg.key[3:0];
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {upb_pkg::nibble_level(blue_n),
                       upb_pkg::nibble_level(green_n),
                       upb_pkg::nibble_level(red_n),
                       8'(out_reg.hit_index)};
    assign m_tuser  = {!out_reg.found, out_reg.is_new};

    // A token leaves the chain only while a colour is in flight
    a_arrive_busy: assert property (@(posedge clk) disable iff (!rst_n)
        arrive |-> busy_reg)
        else $error("token left the chain with no colour in flight");

    // The skid beat is only used behind a stalled output
    a_hold_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        hold_valid_reg |-> out_valid_reg)
        else $error("skid beat held with output register empty");

    // Fill count never passes the table depth
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= upb_pkg::CNT_W'(N))
        else $error("fill count beyond table depth");

    // An appended colour is never also reported as a full table
    a_new_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("result marked both new and full");

endmodule
